// ===== sv/ir_packet_framer_checker_assert.svh =====
// Assertion macros used by the framer/checker top-level RTL.
`ifndef IR_PACKET_FRAMER_CHECKER_ASSERT_SVH
`define IR_PACKET_FRAMER_CHECKER_ASSERT_SVH

// Clocked check, masked while reset is asserted.
`define IRPFC_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("irpfc check failed");

// Clocked check that also holds through reset.
`define IRPFC_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("irpfc check failed");

`endif

// ===== sv/irpfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfc_pkg
// Types and constants for the IR packet framer/checker.
// ----------------------------------------------------------------------------
package irpfc_pkg;

  localparam int unsigned MaxPacketBytes = 256;
  localparam int unsigned PosW           = $clog2(MaxPacketBytes);

  localparam logic [PosW-1:0] MaxPos   = PosW'(MaxPacketBytes - 1);
  localparam logic [7:0]      LineMask = 8'hAA;
  localparam logic [15:0]     ChkMask  = 16'hAAAA;
  localparam logic [15:0]     SumSeed  = 16'h0002;
  localparam int unsigned     HdrBytes = 8;

  typedef enum logic {
    OpSend = 1'b0,
    OpRecv = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StBadChk   = 2'd1,
    StBadSess  = 2'd2,
    StShort    = 2'd3
  } status_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_last;
    logic [15:0] coded_checksum;
    logic [1:0]  status;
  } out_item_t;

  // Handshake between the pipeline registers and the packet core.
  typedef struct packed {
    logic s1_vld;   // input register holds an item
    logic advance;  // item moves into the result register this cycle
  } pipe_ctl_t;

endpackage

// ===== sv/ir_packet_framer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_packet_framer_checker
// Frames (send) or checks (receive) IR link packets one byte per transfer.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------
//  in      | in_valid_i / in_stall_o | in_data_i  (in_item_t)
//  out     | out_valid_o/ out_stall_i| out_data_o (out_item_t)
//  cfg     | cfg_valid_i/ cfg_ready_o| cfg_data_i (session key)
//
//  One byte per cycle while out is not stalled; a result is presented on out
//  after passing the input register, then the result register, with one
//  16-bit add between them.
//  Reset clears packet state, session key and both valid flags; no sweep.
//  A stall on out backs up through the input register to in_stall_o.
//  cfg_ready_o is always high.
// ----------------------------------------------------------------------------
module ir_packet_framer_checker
  import irpfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

`include "ir_packet_framer_checker_assert.svh"

  pipe_ctl_t ctl;
  in_item_t  item;
  out_item_t res;
  logic      s2_free;

  assign cfg_ready_o = 1'b1;

  irpfc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .s2_free_i  (s2_free),
    .ctl_o      (ctl),
    .item_o     (item)
  );

  irpfc_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .ctl_i      (ctl),
    .item_i     (item),
    .res_o      (res)
  );

  irpfc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .res_i       (res),
    .s2_free_o   (s2_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // status and checksum only ever appear on a packet's final result
  `IRPFC_ASSERT(a_status_on_last, clk_i, rst_ni, (out_valid_o && out_data_o.status != StOk) |-> out_data_o.out_last)
  `IRPFC_ASSERT(a_chk_on_last, clk_i, rst_ni, (out_valid_o && out_data_o.coded_checksum != 16'h0) |-> out_data_o.out_last)
  // upstream stalls only when a held result is being stalled downstream
  `IRPFC_ASSERT_ALWAYS(a_stall_cause, clk_i, in_stall_o |-> (out_valid_o && out_stall_i))
  // a held input item is not dropped while the result side is blocked
  `IRPFC_ASSERT(a_hold_item, clk_i, rst_ni, (ctl.s1_vld && !ctl.advance) |=> ctl.s1_vld)

endmodule

// ===== sv/irpfc_in_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfc_in_stage
// Input register: captures one byte item per transfer, holds it until the
// result register can take its result.
// ----------------------------------------------------------------------------
module irpfc_in_stage
  import irpfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  input  logic      s2_free_i,
  output pipe_ctl_t ctl_o,
  output in_item_t  item_o
);

  logic     vld_q, vld_d;
  in_item_t item_q;
  logic     advance;
  logic     take;

  assign advance    = vld_q && s2_free_i;
  assign in_stall_o = vld_q && !s2_free_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (advance) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_data_i;
    end
  end

  assign ctl_o.s1_vld  = vld_q;
  assign ctl_o.advance = advance;
  assign item_o        = item_q;

endmodule

// ===== sv/irpfc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfc_core
// Packet state and per-byte framing: header substitution, line coding,
// end-around-carry sum and receive-side checks.
// ----------------------------------------------------------------------------
module irpfc_core
  import irpfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  pipe_ctl_t   ctl_i,
  input  in_item_t    item_i,
  output out_item_t   res_o
);

  logic [31:0]     key_q;
  logic [15:0]     sum_q, sum_d;
  logic [PosW-1:0] pos_q, pos_d;
  op_e             dir_q, dir_d;
  logic [15:0]     rxchk_q, rxchk_d;
  logic            sess_ok_q, sess_ok_d;

  logic        last;
  logic        is_hdr_chk;
  logic        is_sess;
  op_e         dir;
  logic [7:0]  key_byte;
  logic [7:0]  dec_byte;
  logic [7:0]  plain;
  logic [7:0]  addend;
  logic [15:0] addend_w;
  logic [16:0] raw_sum;
  logic [15:0] new_sum;

  assign last       = item_i.in_last || (pos_q == MaxPos);
  assign is_hdr_chk = (pos_q == PosW'(2)) || (pos_q == PosW'(3));
  assign is_sess    = (pos_q >= PosW'(4)) && (pos_q < PosW'(HdrBytes));
  assign dir        = (pos_q == '0) ? item_i.op : dir_q;
  // offsets 4..7 map to key bytes 0..3
  assign key_byte   = key_q[8*pos_q[1:0] +: 8];
  assign dec_byte   = item_i.in_byte ^ LineMask;

  always_comb begin
    plain = item_i.in_byte;
    if (is_hdr_chk) begin
      plain = 8'h00;
    end else if (is_sess) begin
      plain = key_byte;
    end
  end

  assign addend   = is_hdr_chk ? 8'h00 : ((dir == OpSend) ? plain : dec_byte);
  assign addend_w = pos_q[0] ? {8'h00, addend} : {addend, 8'h00};
  assign raw_sum  = {1'b0, sum_q} + {1'b0, addend_w};
  assign new_sum  = raw_sum[15:0] + {15'd0, raw_sum[16]};

  always_comb begin
    rxchk_d   = rxchk_q;
    sess_ok_d = sess_ok_q;
    if (dir == OpRecv) begin
      if (pos_q == PosW'(2)) begin
        rxchk_d[7:0] = dec_byte;
      end else if (pos_q == PosW'(3)) begin
        rxchk_d[15:8] = dec_byte;
      end else if (is_sess && (dec_byte != key_byte)) begin
        sess_ok_d = 1'b0;
      end
    end
  end

  always_comb begin
    res_o.out_byte       = (dir == OpSend) ? (plain ^ LineMask) : dec_byte;
    res_o.out_last       = last;
    res_o.coded_checksum = 16'h0000;
    res_o.status         = StOk;
    if (last) begin
      if (dir == OpSend) begin
        res_o.coded_checksum = new_sum ^ ChkMask;
      end else if (pos_q < PosW'(HdrBytes - 1)) begin
        res_o.status = StShort;
      end else if (rxchk_d != new_sum) begin
        res_o.status = StBadChk;
      end else if (!sess_ok_d) begin
        res_o.status = StBadSess;
      end
    end
  end

  // Packet state steps only when the item commits to the result register.
  always_comb begin
    sum_d = sum_q;
    pos_d = pos_q;
    dir_d = dir_q;
    if (ctl_i.advance) begin
      if (last) begin
        sum_d = SumSeed;
        pos_d = '0;
        dir_d = OpSend;
      end else begin
        sum_d = new_sum;
        pos_d = pos_q + PosW'(1);
        dir_d = dir;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= 32'h0;
      sum_q     <= SumSeed;
      pos_q     <= '0;
      dir_q     <= OpSend;
      rxchk_q   <= 16'h0;
      sess_ok_q <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        key_q <= cfg_data_i;
      end
      sum_q <= sum_d;
      pos_q <= pos_d;
      dir_q <= dir_d;
      if (ctl_i.advance) begin
        rxchk_q   <= last ? 16'h0 : rxchk_d;
        sess_ok_q <= last ? 1'b1 : sess_ok_d;
      end
    end
  end

endmodule

// ===== sv/irpfc_out_stage.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpfc_out_stage
// Result register: holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module irpfc_out_stage
  import irpfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  pipe_ctl_t ctl_i,
  input  out_item_t res_i,
  output logic      s2_free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      vld_q, vld_d;
  out_item_t data_q;

  assign s2_free_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q && out_stall_i;
    if (ctl_i.advance) begin
      vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.advance) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

// ===== test/ir_packet_framer_checker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_packet_framer_checker_test
// Self-checking bench for the IR packet framer/checker. A directed table
// covers single-byte packets, header handling and the receive status
// priority. Random send, receive and noise packets follow, over several
// session keys and idle/stall patterns. Results are compared with a byte-level
// model of the framer or, for rows with a typed-in result, with that result.
// ----------------------------------------------------------------------------
module ir_packet_framer_checker_test;
  import irpfc_pkg::*;

  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned PhaseItems  = 340;
  localparam int unsigned NumPhases   = 5;
  localparam int unsigned NumDirected = 21;

  // directed row: input byte, whether the result is typed in, and that result
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } dir_row_t;

  localparam out_item_t NoWant = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [31:0] cfg_data_i = '0;

  ir_packet_framer_checker dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // framer model state
  logic [31:0] sess_key   = '0;
  logic [15:0] run_sum    = SumSeed;
  int          pkt_pos    = 0;
  op_e         pkt_dir    = OpSend;
  logic [15:0] rx_chk     = '0;
  logic        sess_match = 1'b1;

  out_item_t   framer_out_q [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int unsigned cycles = 0;
  dir_row_t    dir_vec [NumDirected];

  // 16-bit end-around-carry add; even offsets land in the high byte
  function automatic logic [15:0] ones_add(input logic [15:0] s, input int pos,
                                           input logic [7:0] b);
    logic [16:0] t;
    t = {1'b0, s} + ((pos % 2) ? {9'h0, b} : {1'b0, b, 8'h00});
    return t[15:0] + {15'h0, t[16]};
  endfunction

  function automatic out_item_t frame_step(input in_item_t it);
    out_item_t  r;
    logic [7:0] plain;
    logic [7:0] kb;
    logic       fin;
    logic       hdr_chk;
    logic       sess;
    r       = '0;
    fin     = it.in_last || (pkt_pos >= int'(MaxPacketBytes) - 1);
    hdr_chk = (pkt_pos == 2) || (pkt_pos == 3);
    sess    = (pkt_pos >= 4) && (pkt_pos < int'(HdrBytes));
    kb      = 8'(sess_key >> (8 * (pkt_pos % 4)));
    if (pkt_pos == 0) pkt_dir = it.op;
    if (pkt_dir == OpSend) begin
      plain = hdr_chk ? 8'h00 : (sess ? kb : it.in_byte);
      run_sum = ones_add(run_sum, pkt_pos, plain);
      r.out_byte = plain ^ LineMask;
      if (fin) r.coded_checksum = run_sum ^ ChkMask;
    end else begin
      plain = it.in_byte ^ LineMask;
      r.out_byte = plain;
      if (pkt_pos == 2) rx_chk[7:0] = plain;
      else if (pkt_pos == 3) rx_chk[15:8] = plain;
      else if (sess && plain != kb) sess_match = 1'b0;
      run_sum = ones_add(run_sum, pkt_pos, hdr_chk ? 8'h00 : plain);
      if (fin) begin
        // checksum is judged before session
        if (pkt_pos + 1 < int'(HdrBytes)) r.status = StShort;
        else if (rx_chk != run_sum) r.status = StBadChk;
        else if (!sess_match) r.status = StBadSess;
        else r.status = StOk;
      end
    end
    r.out_last = fin;
    if (fin) begin
      run_sum    = SumSeed;
      pkt_pos    = 0;
      pkt_dir    = OpSend;
      rx_chk     = '0;
      sess_match = 1'b1;
    end else begin
      pkt_pos++;
    end
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic push_byte(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i  = it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = frame_step(it);
    framer_out_q.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_key(input logic [31:0] v);
    cfg_valid_i = 1'b1;
    cfg_data_i  = v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sess_key = v;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (framer_out_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // One random packet: plain send, well-formed receive (sometimes with a bad
  // checksum or session byte), or line noise. A few run past the size limit.
  task automatic gen_packet();
    in_item_t    it;
    logic [7:0]  pkt [0:299];
    logic [15:0] s;
    int          len;
    int          kind;
    int          fault;
    int          r;
    r = $urandom_range(99);
    if (r < 80) len = $urandom_range(20, 1);
    else if (r < 96) len = $urandom_range(64, 21);
    else len = $urandom_range(300, 240);
    kind  = $urandom_range(99);
    fault = $urandom_range(3);
    if (kind >= 35 && kind < 75 && len <= int'(MaxPacketBytes)) begin
      s = SumSeed;
      for (int i = 0; i < len; i++) begin
        if (i == 2 || i == 3) pkt[i] = 8'h00;
        else if (i >= 4 && i < int'(HdrBytes)) pkt[i] = 8'(sess_key >> (8 * (i % 4)));
        else pkt[i] = 8'($urandom);
        if (fault == 2 && i == 4 + int'($urandom_range(3)))
          pkt[i] = pkt[i] ^ 8'($urandom_range(255, 1));
        s = ones_add(s, i, pkt[i]);
      end
      if (fault == 1) s = s ^ 16'(1 << $urandom_range(15));
      if (len > 2) pkt[2] = s[7:0];
      if (len > 3) pkt[3] = s[15:8];
      for (int i = 0; i < len; i++) pkt[i] = pkt[i] ^ LineMask;
    end else begin
      for (int i = 0; i < len; i++) pkt[i] = 8'($urandom);
    end
    for (int i = 0; i < len; i++) begin
      it.op      = (i == 0) ? ((kind < 35) ? OpSend : OpRecv) : op_e'($urandom_range(1));
      it.in_byte = pkt[i];
      it.in_last = (i == len - 1);
      push_byte(it, 1'b0, NoWant);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (framer_out_q.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: byte %h last %b chk %h status %0d",
                   out_data_o.out_byte, out_data_o.out_last,
                   out_data_o.coded_checksum, out_data_o.status);
        mismatches++;
      end else begin
        exp_item = framer_out_q.pop_front();
        if (out_data_o.out_byte !== exp_item.out_byte ||
            out_data_o.out_last !== exp_item.out_last ||
            out_data_o.coded_checksum !== exp_item.coded_checksum ||
            out_data_o.status !== exp_item.status) begin
          if (mismatches < 10)
            $display("result mismatch: exp byte %h last %b chk %h status %0d, got byte %h last %b chk %h status %0d",
                     exp_item.out_byte, exp_item.out_last, exp_item.coded_checksum,
                     exp_item.status, out_data_o.out_byte, out_data_o.out_last,
                     out_data_o.coded_checksum, out_data_o.status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [31:0] phase_key  [NumPhases];
    int          phase_idle [NumPhases];
    int          phase_stall[NumPhases];
    phase_key   = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, $urandom, $urandom};
    phase_idle  = '{0, 82, 0, 38, 0};
    phase_stall = '{0, 0, 82, 38, 0};

    // session key is zero from reset for the whole table
    dir_vec = '{
      {OpSend, 8'h00, 1'b1, 1'b1, 8'hAA, 1'b1, 16'hAAA8, StOk},
      {OpSend, 8'hFF, 1'b1, 1'b1, 8'h55, 1'b1, 16'h55A8, StOk},
      {OpRecv, 8'hAA, 1'b1, 1'b1, 8'h00, 1'b1, 16'h0000, StShort},
      {OpRecv, 8'h55, 1'b1, 1'b1, 8'hFF, 1'b1, 16'h0000, StShort},
      // send header; op flips after the first byte and must be ignored
      {OpSend, 8'h80, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'h01, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'hFF, 1'b0, 1'b0, NoWant},
      {OpSend, 8'h7F, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'h11, 1'b0, 1'b0, NoWant},
      {OpSend, 8'h22, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'h33, 1'b0, 1'b0, NoWant},
      {OpSend, 8'h44, 1'b1, 1'b0, NoWant},
      // receive: wrong checksum and wrong session byte, checksum wins
      {OpRecv, 8'hB8, 1'b0, 1'b0, NoWant},
      {OpSend, 8'h9E, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'hAA, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'hAA, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'hAB, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'hAA, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'hAA, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'hAA, 1'b0, 1'b0, NoWant},
      {OpRecv, 8'hFC, 1'b1, 1'b1, 8'h56, 1'b1, 16'h0000, StBadChk}
    };

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++)
      push_byte(dir_vec[i].item, dir_vec[i].typed, dir_vec[i].want);

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      write_key(phase_key[p]);
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      while (items_sent < NumDirected + (p + 1) * PhaseItems) gen_packet();
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && framer_out_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
